[src/sbsc_pkg.sv]
// ----------------------------------------------------------------------------
// sbsc_pkg - scoreboard controller constants
// Register indexes, key bit positions and clock limits shared by the RTL.
// ----------------------------------------------------------------------------
package sbsc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_SHOT_RELOAD = 3'd0;
    localparam logic [2:0] REG_TICKS_PER_S = 3'd1;
    localparam logic [2:0] REG_GAME_ALARM  = 3'd2;
    localparam logic [2:0] REG_SHOT_ALARM  = 3'd3;
    localparam logic [2:0] REG_DEBOUNCE    = 3'd4;

    // key bit positions
    localparam int KEY_HOME       = 0;
    localparam int KEY_GUEST      = 1;
    localparam int KEY_CLOCK_GO   = 2;
    localparam int KEY_CLOCK_HALT = 3;
    localparam int KEY_SET        = 4;
    localparam int KEY_ADD        = 5;
    localparam int KEY_DEC        = 6;
    localparam int KEY_OVERTIME   = 7;
    localparam int KEY_SHOT_STOP  = 8;
    localparam int KEY_SHOT_RUN   = 9;

    // item kinds
    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [13:0] SCORE_MAX      = 14'd9999;
    localparam logic [12:0] GAME_ADD_LIMIT = 13'd5880;  // 99 min less one minute
    localparam logic [12:0] GAME_OT_LIMIT  = 13'd5640;  // 99 min less five minutes
    localparam logic [12:0] GAME_RESET     = 13'd600;
    localparam logic [12:0] MINUTE         = 13'd60;
    localparam logic [12:0] OVERTIME       = 13'd300;
    localparam logic [6:0]  SHOT_RESET     = 7'd24;

    localparam logic [6:0]  RELOAD_RESET   = 7'd24;
    localparam logic [15:0] TPS_RESET      = 16'd1000;
    localparam logic [11:0] GAME_AL_RESET  = 12'd3000;
    localparam logic [11:0] SHOT_AL_RESET  = 12'd1500;
    localparam logic [3:0]  DEBOUNCE_RESET = 4'd3;

    // alarm / 100 as (alarm * BLINK_RECIP) >> BLINK_SHIFT, exact for 12-bit alarm
    localparam logic [12:0] BLINK_RECIP = 13'd5243;
    localparam int          BLINK_SHIFT = 19;

endpackage

[src/scoreboard_game_and_shot_clock_top.sv]
// ----------------------------------------------------------------------------
// scoreboard_game_and_shot_clock_top - basketball scoreboard controller
// Debounced keys, saturating scores, game clock, shot clock and alarm blink.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item per beat: action 0 is
//   a millisecond tick, action 1 a raw sample of the ten keys. Every item
//   gives exactly one result beat on the output channel (out_valid /
//   out_stall) holding the scores, both clocks, run and set flags, the alarm
//   drive and the key events accepted by that item.
//   An accepted item passes through the input register, then the result
//   register. Throughput: one item per cycle unless out_stall holds a full
//   result register; the whole update is a single pass of logic between
//   the two registers, the alarm blink bit being one 12x13 constant multiply.
//   Stall: when the result register is full and out_stall is high, the item in
//   the input register waits and in_stall rises; nothing is dropped.
//   Reset (rst_n low, async): scores 0, game clock 600 s, shot clock 24 s,
//   clocks stopped, alarm count cleared, debounce history cleared, registers at their
//   defaults (reload 24, 1000 ticks/s, alarms 3000/1500 ticks, debounce 3).
//   Config writes (cfg_we, cfg_index, cfg_data) take effect at the clock edge;
//   the user must issue them only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module scoreboard_game_and_shot_clock_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [9:0]  keys_pressed,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [13:0] score_home,
    output logic [13:0] score_guest,
    output logic [12:0] game_seconds,
    output logic [6:0]  shot_seconds,
    output logic        game_running,
    output logic        shot_running,
    output logic        setting_mode,
    output logic        alarm_on,
    output logic [9:0]  key_events
);

    // configuration registers
    logic [6:0]  shot_reload_reg;
    logic [15:0] ticks_per_s_reg;
    logic [11:0] game_alarm_reg;
    logic [11:0] shot_alarm_reg;
    logic [3:0]  debounce_reg;

    // input stage
    logic        s1_valid_reg;
    logic        s1_action_reg;
    logic [9:0]  s1_keys_reg;

    // scoreboard state
    logic [13:0] home_reg,     home_next;
    logic [13:0] guest_reg,    guest_next;
    logic [12:0] game_reg,     game_next;
    logic [6:0]  shot_reg,     shot_next;
    logic        game_run_reg, game_run_next;
    logic        shot_run_reg, shot_run_next;
    logic        adjust_reg,   adjust_next;
    logic [11:0] alarm_reg,    alarm_next;
    logic [15:0] tick_reg,     tick_next;
    logic [9:0]  prev_reg,     prev_next;
    logic [9:0]  acc_reg,      acc_next;
    logic [3:0]  same_reg,     same_next;

    // result register
    logic        out_valid_reg;
    logic        alarm_on_reg;
    logic [9:0]  events_reg;

    logic        advance;
    logic [9:0]  ev;
    logic [15:0] tick_inc;
    logic [24:0] blink_prod;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;

    // ---------------- config port ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shot_reload_reg <= sbsc_pkg::RELOAD_RESET;
            ticks_per_s_reg <= sbsc_pkg::TPS_RESET;
            game_alarm_reg  <= sbsc_pkg::GAME_AL_RESET;
            shot_alarm_reg  <= sbsc_pkg::SHOT_AL_RESET;
            debounce_reg    <= sbsc_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sbsc_pkg::REG_SHOT_RELOAD: shot_reload_reg <= cfg_data[6:0];
                sbsc_pkg::REG_TICKS_PER_S: ticks_per_s_reg <= cfg_data;
                sbsc_pkg::REG_GAME_ALARM:  game_alarm_reg  <= cfg_data[11:0];
                sbsc_pkg::REG_SHOT_ALARM:  shot_alarm_reg  <= cfg_data[11:0];
                sbsc_pkg::REG_DEBOUNCE:    debounce_reg    <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_action_reg <= action;
            s1_keys_reg   <= keys_pressed;
        end
    end

    // ---------------- item update ----------------
    assign tick_inc = tick_reg + 16'd1;

    always_comb
    begin
        home_next     = home_reg;
        guest_next    = guest_reg;
        game_next     = game_reg;
        shot_next     = shot_reg;
        game_run_next = game_run_reg;
        shot_run_next = shot_run_reg;
        adjust_next   = adjust_reg;
        alarm_next    = alarm_reg;
        tick_next     = tick_reg;
        prev_next     = prev_reg;
        acc_next      = acc_reg;
        same_next     = same_reg;
        ev            = '0;

        if (s1_action_reg == sbsc_pkg::ACT_SAMPLE)
        begin
            // debounce: a stable sample that differs from the accepted keys
            if (s1_keys_reg == prev_reg)
            begin
                if (same_reg < debounce_reg)
                begin
                    same_next = same_reg + 4'd1;
                end
                else if (s1_keys_reg != acc_reg)
                begin
                    ev       = s1_keys_reg & ~acc_reg;
                    acc_next = s1_keys_reg;
                end
            end
            else
            begin
                same_next = '0;
                prev_next = s1_keys_reg;
            end

            // events in fixed priority order; later ones see earlier updates
            if (ev[sbsc_pkg::KEY_HOME] && home_next < sbsc_pkg::SCORE_MAX)
                home_next = home_next + 14'd1;
            if (ev[sbsc_pkg::KEY_GUEST] && guest_next < sbsc_pkg::SCORE_MAX)
                guest_next = guest_next + 14'd1;
            if (ev[sbsc_pkg::KEY_CLOCK_GO])
            begin
                adjust_next = 1'b0;
                if (game_next != '0)
                    game_run_next = 1'b1;
            end
            if (ev[sbsc_pkg::KEY_CLOCK_HALT])
                game_run_next = 1'b0;
            if (ev[sbsc_pkg::KEY_SET])
            begin
                adjust_next   = !adjust_next;
                game_run_next = 1'b0;
                shot_run_next = 1'b0;
            end
            if (ev[sbsc_pkg::KEY_ADD] && adjust_next && game_next <= sbsc_pkg::GAME_ADD_LIMIT)
                game_next = game_next + sbsc_pkg::MINUTE;
            if (ev[sbsc_pkg::KEY_DEC] && adjust_next && game_next >= sbsc_pkg::MINUTE)
                game_next = game_next - sbsc_pkg::MINUTE;
            if (ev[sbsc_pkg::KEY_OVERTIME])
            begin
                if (game_next <= sbsc_pkg::GAME_OT_LIMIT)
                    game_next = game_next + sbsc_pkg::OVERTIME;
                game_run_next = 1'b0;
                shot_run_next = 1'b0;
                adjust_next   = 1'b0;
            end
            if (ev[sbsc_pkg::KEY_SHOT_STOP])
                shot_run_next = 1'b0;
            if (ev[sbsc_pkg::KEY_SHOT_RUN])
            begin
                shot_next     = shot_reload_reg;
                shot_run_next = 1'b1;
            end
        end
        else
        begin
            // millisecond tick
            tick_next = tick_inc;
            if (tick_inc >= ticks_per_s_reg)
            begin
                tick_next = '0;
                if (game_run_reg && game_reg != '0)
                begin
                    game_next = game_reg - 13'd1;
                    if (game_next == '0)
                    begin
                        game_run_next = 1'b0;
                        shot_run_next = 1'b0;
                        alarm_next    = game_alarm_reg;
                    end
                end
                if (shot_run_next && shot_reg != '0)
                begin
                    shot_next = shot_reg - 7'd1;
                    if (shot_next == '0)
                    begin
                        shot_run_next = 1'b0;
                        alarm_next    = shot_alarm_reg;
                    end
                end
            end
            if (alarm_next != '0)
                alarm_next = alarm_next - 12'd1;
        end
    end

    // blink bit: bit 0 of alarm / 100
    assign blink_prod = 25'(alarm_next) * 25'(sbsc_pkg::BLINK_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_reg     <= '0;
            guest_reg    <= '0;
            game_reg     <= sbsc_pkg::GAME_RESET;
            shot_reg     <= sbsc_pkg::SHOT_RESET;
            game_run_reg <= 1'b0;
            shot_run_reg <= 1'b0;
            adjust_reg   <= 1'b0;
            alarm_reg    <= '0;
            tick_reg     <= '0;
            prev_reg     <= '0;
            acc_reg      <= '0;
            same_reg     <= '0;
        end
        else if (advance)
        begin
            home_reg     <= home_next;
            guest_reg    <= guest_next;
            game_reg     <= game_next;
            shot_reg     <= shot_next;
            game_run_reg <= game_run_next;
            shot_run_reg <= shot_run_next;
            adjust_reg   <= adjust_next;
            alarm_reg    <= alarm_next;
            tick_reg     <= tick_next;
            prev_reg     <= prev_next;
            acc_reg      <= acc_next;
            same_reg     <= same_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            alarm_on_reg <= blink_prod[sbsc_pkg::BLINK_SHIFT];
            events_reg   <= ev;
        end
    end

    // state registers only move on advance, so they mirror the held result
    assign out_valid    = out_valid_reg;
    assign score_home   = home_reg;
    assign score_guest  = guest_reg;
    assign game_seconds = game_reg;
    assign shot_seconds = shot_reg;
    assign game_running = game_run_reg;
    assign shot_running = shot_run_reg;
    assign setting_mode = adjust_reg;
    assign alarm_on     = alarm_on_reg;
    assign key_events   = events_reg;

endmodule
